// ----- src/pms_pkg.sv -----
// Package for the permutation sampler kernel: widths, codes and memory entry types.
// No dependencies; used by the top level.
package pms_pkg;

   localparam int SLOT_BITS     = 10;
   localparam int SLOTS         = 1 << SLOT_BITS;
   localparam int SYM_W         = 10;
   localparam int LP_W          = 24;
   localparam int MULT_W        = 16;
   localparam int ACC_W         = 63;
   localparam int TICK_W        = 32;
   localparam int LOG_FRAC_BITS = 16;
   localparam int LOG_FLOOR_INT = -100;

   localparam logic signed [LP_W-1:0] LOG_FLOOR =
      LP_W'(LOG_FLOOR_INT * (1 << LOG_FRAC_BITS));

   localparam int DLOG_W = LP_W + 1;
   localparam int DMU_W  = MULT_W + 1;
   localparam int PROD_W = DLOG_W + DMU_W;
   localparam int HELD_W = TICK_W + MULT_W;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 112;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_PROPOSE = 2'd2;
   localparam logic [1:0] KIND_DRAIN   = 2'd3;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_SAME     = 3'd3;
   localparam logic [2:0] ST_DRAINED  = 3'd4;

   typedef struct packed {
      logic [MULT_W-1:0] mult;
      logic [SYM_W-1:0]  sym;
   } pos_entry_type;

   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [TICK_W-1:0] stamp;
   } visit_entry_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [HELD_W-1:0] add);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {(ACC_W + 1 - HELD_W)'(0), add};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

   function automatic logic [TICK_W-1:0] held_time(input logic [TICK_W-1:0] tick,
                                                   input logic [TICK_W-1:0] stamp);
      logic [TICK_W:0] diff;
      diff = {1'b0, tick} - {1'b0, stamp};
      return diff[TICK_W] ? '0 : diff[TICK_W-1:0];
   endfunction

endpackage

// ----- src/pms_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pms_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [1 << ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/permutation_metropolis_sampler_top.sv -----
// Metropolis-Hastings permutation sampler kernel, top level.
// Each result waits until the response output is free.
// One request at a time: the next is taken only after the result is registered;
// the reads of each memory are serial (one read port).
// Reset: synchronous; a clearing pass over all 1024 visit memory entries follows, no requests taken.
module permutation_metropolis_sampler_top
   import pms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_a[9:0], pos_b[19:10], accept_log[43:20], load_log_prob[67:44],
   // load_mult[83:68], load_symbol[93:84], zero[95:94]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // symbol[9:0], weight[72:10], tick_now[104:73], zero[111:105]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]            rsp_tuser
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_LOAD, S_RD_A, S_RD_B, S_RD_SA, S_RD_SB,
      S_CALC, S_MUL, S_DEC, S_WR2, S_DR1, S_DR2, S_DR3, S_EMIT
   } state_type;

   state_type               state_ff;
   logic [SLOT_BITS-1:0]    clr_cnt_ff;
   logic                    start_pend_ff;
   logic [TICK_W-1:0]       tick_ff;
   logic [1:0]              kind_ff;
   logic [SLOT_BITS-1:0]    a_ff, b_ff;
   logic signed [LP_W-1:0]  accept_log_ff, load_lp_ff;
   logic [MULT_W-1:0]       load_mult_ff;
   logic [SYM_W-1:0]        load_sym_ff;
   pos_entry_type           pos_a_ff, pos_b_ff;
   logic signed [LP_W-1:0]  lp_a_ff;
   logic [ACC_W-1:0]        acc_a_ff, acc_b_ff, acc_new_a_ff;
   logic [TICK_W-1:0]       stamp_a_ff, dt_a_ff, dt_b_ff;
   logic signed [DLOG_W-1:0] dlog_ff;
   logic signed [DMU_W-1:0] dmu_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [HELD_W-1:0]       wa_ff, wb_ff;
   logic [2:0]              res_status_ff;
   logic [SYM_W-1:0]        res_sym_ff;
   logic [ACC_W-1:0]        res_weight_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [2:0]              rsp_user_ff;

   logic                    pos_we;
   logic [SLOT_BITS-1:0]    pos_wr_addr, pos_rd_addr;
   pos_entry_type           pos_wr_data, pos_rd;
   logic                    lp_we;
   logic [SLOT_BITS-1:0]    lp_rd_addr;
   logic signed [LP_W-1:0]  lp_wr_data, lp_rd;
   logic                    vis_we;
   logic [SLOT_BITS-1:0]    vis_wr_addr, vis_rd_addr;
   visit_entry_type         vis_wr_data, vis_rd;
   logic                    req_fire, accept_ok, out_free;
   logic [ACC_W-1:0]        acc_a_new, acc_b_src;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign accept_ok  = !(PROD_W'(accept_log_ff) > prod_ff);
   assign acc_a_new  = sat_add(acc_a_ff, wa_ff);
   assign acc_b_src  = (pos_a_ff.sym == pos_b_ff.sym) ? acc_new_a_ff : acc_b_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      pos_we      = 1'b0;
      pos_wr_addr = a_ff;
      pos_wr_data = '{mult: load_mult_ff, sym: load_sym_ff};
      pos_rd_addr = (state_ff == S_RD_B) ? b_ff : a_ff;
      lp_we       = (state_ff == S_LOAD);
      lp_wr_data  = (load_lp_ff < LOG_FLOOR) ? LOG_FLOOR : load_lp_ff;
      lp_rd_addr  = (state_ff == S_RD_SB) ? pos_b_ff.sym : pos_a_ff.sym;
      vis_we      = 1'b0;
      vis_wr_addr = clr_cnt_ff;
      vis_wr_data = '{acc: '0, stamp: '0};
      vis_rd_addr = pos_a_ff.sym;
      unique case (state_ff)
         S_CLR: begin
            vis_we = 1'b1;
         end
         S_LOAD: begin
            pos_we = 1'b1;
         end
         S_RD_B: begin
            vis_rd_addr = pos_rd.sym;
         end
         S_RD_SB: begin
            vis_rd_addr = pos_b_ff.sym;
         end
         S_DEC: begin
            pos_we      = accept_ok;
            pos_wr_data = '{mult: pos_a_ff.mult, sym: pos_b_ff.sym};
            vis_we      = accept_ok;
            vis_wr_addr = pos_a_ff.sym;
            vis_wr_data = '{acc: acc_a_new, stamp: tick_ff};
         end
         S_WR2: begin
            pos_we      = 1'b1;
            pos_wr_addr = b_ff;
            pos_wr_data = '{mult: pos_b_ff.mult, sym: pos_a_ff.sym};
            vis_we      = 1'b1;
            vis_wr_addr = pos_b_ff.sym;
            vis_wr_data = '{acc: sat_add(acc_b_src, wb_ff), stamp: tick_ff};
         end
         default: begin
         end
      endcase
   end

   pms_ram #(.ADDR_W(SLOT_BITS), .DATA_W($bits(pos_entry_type))) u_pos_ram (
      .clock   (clock),
      .we      (pos_we),
      .wr_addr (pos_wr_addr),
      .wr_data (pos_wr_data),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd)
   );

   pms_ram #(.ADDR_W(SLOT_BITS), .DATA_W(LP_W)) u_lp_ram (
      .clock   (clock),
      .we      (lp_we),
      .wr_addr (a_ff),
      .wr_data (lp_wr_data),
      .rd_addr (lp_rd_addr),
      .rd_data (lp_rd)
   );

   pms_ram #(.ADDR_W(SLOT_BITS), .DATA_W($bits(visit_entry_type))) u_vis_ram (
      .clock   (clock),
      .we      (vis_we),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_cnt_ff    <= '0;
         start_pend_ff <= 1'b0;
         tick_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == SLOT_BITS'(SLOTS - 1)) begin
                  res_status_ff <= ST_DONE;
                  res_sym_ff    <= '0;
                  res_weight_ff <= '0;
                  state_ff      <= start_pend_ff ? S_EMIT : S_IDLE;
                  start_pend_ff <= 1'b0;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  kind_ff       <= req_tuser;
                  a_ff          <= req_tdata[9:0];
                  b_ff          <= req_tdata[19:10];
                  accept_log_ff <= req_tdata[43:20];
                  load_lp_ff    <= req_tdata[67:44];
                  load_mult_ff  <= req_tdata[83:68];
                  load_sym_ff   <= req_tdata[93:84];
                  unique case (req_tuser)
                     KIND_LOAD: begin
                        state_ff <= S_LOAD;
                     end
                     KIND_START: begin
                        tick_ff       <= '0;
                        clr_cnt_ff    <= '0;
                        start_pend_ff <= 1'b1;
                        state_ff      <= S_CLR;
                     end
                     KIND_PROPOSE: begin
                        if ((req_tdata[9:0] != req_tdata[19:10]) && (tick_ff != '1)) begin
                           tick_ff <= tick_ff + 1'b1;
                        end
                        state_ff <= S_RD_A;
                     end
                     KIND_DRAIN: begin
                        state_ff <= S_RD_A;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_LOAD: begin
               res_status_ff <= ST_DONE;
               res_sym_ff    <= load_sym_ff;
               res_weight_ff <= '0;
               state_ff      <= S_EMIT;
            end
            S_RD_A: begin
               state_ff <= S_RD_B;
            end
            S_RD_B: begin
               pos_a_ff <= pos_rd;
               if (kind_ff == KIND_DRAIN) begin
                  state_ff <= S_DR1;
               end else if (a_ff == b_ff) begin
                  res_status_ff <= ST_SAME;
                  res_sym_ff    <= pos_rd.sym;
                  res_weight_ff <= '0;
                  state_ff      <= S_EMIT;
               end else begin
                  state_ff <= S_RD_SA;
               end
            end
            S_RD_SA: begin
               pos_b_ff <= pos_rd;
               state_ff <= S_RD_SB;
            end
            S_RD_SB: begin
               lp_a_ff    <= lp_rd;
               acc_a_ff   <= vis_rd.acc;
               stamp_a_ff <= vis_rd.stamp;
               state_ff   <= S_CALC;
            end
            S_CALC: begin
               dt_a_ff  <= held_time(tick_ff, stamp_a_ff);
               dt_b_ff  <= held_time(tick_ff, vis_rd.stamp);
               acc_b_ff <= vis_rd.acc;
               dlog_ff  <= DLOG_W'(lp_rd) - DLOG_W'(lp_a_ff);
               dmu_ff   <= $signed({1'b0, pos_a_ff.mult}) - $signed({1'b0, pos_b_ff.mult});
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(dlog_ff) * PROD_W'(dmu_ff);
               wa_ff    <= HELD_W'(dt_a_ff) * HELD_W'(pos_a_ff.mult);
               wb_ff    <= HELD_W'(dt_b_ff) * HELD_W'(pos_b_ff.mult);
               state_ff <= S_DEC;
            end
            S_DEC: begin
               res_weight_ff <= '0;
               if (accept_ok) begin
                  acc_new_a_ff <= acc_a_new;
                  state_ff     <= S_WR2;
               end else begin
                  res_status_ff <= ST_REJECTED;
                  res_sym_ff    <= pos_a_ff.sym;
                  state_ff      <= S_EMIT;
               end
            end
            S_WR2: begin
               res_status_ff <= ST_ACCEPTED;
               res_sym_ff    <= pos_b_ff.sym;
               state_ff      <= S_EMIT;
            end
            S_DR1: begin
               acc_a_ff <= vis_rd.acc;
               dt_a_ff  <= held_time(tick_ff, vis_rd.stamp);
               state_ff <= S_DR2;
            end
            S_DR2: begin
               wa_ff    <= HELD_W'(dt_a_ff) * HELD_W'(pos_a_ff.mult);
               state_ff <= S_DR3;
            end
            S_DR3: begin
               res_status_ff <= ST_DRAINED;
               res_sym_ff    <= pos_a_ff.sym;
               res_weight_ff <= acc_a_new;
               state_ff      <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_status_ff;
                  rsp_data_ff  <= {(RSP_DATA_W - SYM_W - ACC_W - TICK_W)'(0),
                                   tick_ff, res_weight_ff, res_sym_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
